@@ src/lzdht_pkg.sv @@
`default_nettype none
package lzdht_pkg;

  localparam int unsigned BUCKETS_DEFAULT    = 4096;
  localparam int unsigned POOL_NODES_DEFAULT = 4096;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned STEP_W   = $clog2(KEY_W);

  localparam logic [COUNT_W-1:0] BUCKET_COUNT_RESET = 13'd4096;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ src/lzdht_ram.sv @@
`default_nettype none
module lzdht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/lzdht_mod_unit.sv @@
`default_nettype none
// Restoring remainder, one key bit per cycle.
module lzdht_mod_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [lzdht_pkg::KEY_W-1:0]       key,
  input  wire logic [lzdht_pkg::COUNT_W-1:0]     divisor,
  output logic                                   done,
  output logic      [lzdht_pkg::COUNT_W-1:0]     rem
);

  logic                                busy;
  logic [lzdht_pkg::STEP_W-1:0]        step;
  logic [lzdht_pkg::KEY_W-1:0]         key_q;
  logic [lzdht_pkg::COUNT_W-1:0]       div_q;
  logic [lzdht_pkg::COUNT_W:0]         trial;

  assign trial = {rem, key_q[lzdht_pkg::KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '1;
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      key_q <= key;
      div_q <= divisor;
    end else if (busy) begin
      key_q <= key_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem <= lzdht_pkg::COUNT_W'(trial - {1'b0, div_q});
      end else begin
        rem <= lzdht_pkg::COUNT_W'(trial);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/lz78_dictionary_hash_table_top.sv @@
`default_nettype none
// Channel  | handshake               | payload
// -------- | ----------------------- | -------------------------------------
// in       | in_valid / in_stall     | func, symbol, parent_code, new_code
// out      | out_valid / out_stall   | status, child_code
// config   | cfg_wr_en               | cfg_wr_data (bucket_count)
//
// One request at a time. A lookup or insert is accepted, runs through the
// bit-serial remainder unit (16 bit steps and its done cycle), reads its
// bucket head, visits the chain nodes one by one, then posts the result.
// An insert into a full pool answers without hashing.
// After reset the bucket head memory is swept to empty, one bucket per cycle,
// with in_stall held high; config writes are taken meanwhile.
// The finished result waits in an output register while out_stall is high;
// a new request is accepted meanwhile and its result holds until the slot frees.
module lz78_dictionary_hash_table_top #(
  parameter int unsigned BUCKETS    = lzdht_pkg::BUCKETS_DEFAULT,
  parameter int unsigned POOL_NODES = lzdht_pkg::POOL_NODES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [lzdht_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                func,
  input  wire logic [lzdht_pkg::SYMBOL_W-1:0]      symbol,
  input  wire logic [lzdht_pkg::CODE_W-1:0]        parent_code,
  input  wire logic [lzdht_pkg::CODE_W-1:0]        new_code,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [lzdht_pkg::STATUS_W-1:0]      status,
  output logic      [lzdht_pkg::CODE_W-1:0]        child_code
);

  // Bucket index, node index, and link (node number plus one, zero ends a chain).
  localparam int unsigned BAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NAW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned LW  = $clog2(POOL_NODES + 1);
  localparam int unsigned SW  = lzdht_pkg::SYMBOL_W;
  localparam int unsigned CW  = lzdht_pkg::CODE_W;
  // Node word: symbol | parent | child | link
  localparam int unsigned NW  = SW + 2 * CW + LW;

  lzdht_pkg::state_t state, state_next;

  logic [lzdht_pkg::COUNT_W-1:0] bucket_count;
  logic [lzdht_pkg::COUNT_W-1:0] modulus;

  logic [BAW-1:0]  clr_addr;
  logic            func_q;
  logic [SW-1:0]   sym_q;
  logic [CW-1:0]   parent_q;
  logic [CW-1:0]   code_q;
  logic [BAW-1:0]  bucket_q;
  logic [LW-1:0]   head_q;
  logic [LW-1:0]   nodes_used;
  logic [lzdht_pkg::STATUS_W-1:0] res_status;
  logic [CW-1:0]   res_child;

  logic            pool_full;
  logic            mod_start;
  logic            mod_done;
  logic [lzdht_pkg::COUNT_W-1:0] mod_rem;
  logic [lzdht_pkg::KEY_W-1:0]   hash_key;

  logic            head_we;
  logic [BAW-1:0]  head_waddr;
  logic [LW-1:0]   head_wdata;
  logic [BAW-1:0]  head_raddr;
  logic [LW-1:0]   head_rdata;

  logic            node_we;
  logic [NW-1:0]   node_wdata;
  logic [NAW-1:0]  node_raddr;
  logic [NW-1:0]   node_rdata;

  logic [SW-1:0]   nd_sym;
  logic [CW-1:0]   nd_parent;
  logic [CW-1:0]   nd_child;
  logic [LW-1:0]   nd_link;
  logic            nd_match;
  logic [LW-1:0]   chain_head;

  logic            set_result;
  logic [lzdht_pkg::STATUS_W-1:0] set_status;
  logic [CW-1:0]   set_child;
  logic            out_load;

  // Effective modulus: zero acts as one, values above BUCKETS act as BUCKETS.
  always_comb begin
    if (bucket_count == '0) begin
      modulus = lzdht_pkg::COUNT_W'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      modulus = lzdht_pkg::COUNT_W'(BUCKETS);
    end else begin
      modulus = bucket_count;
    end
  end

  // (symbol * 257) xor parent, fits in 16 bits since symbol is 8 bits unsigned.
  assign hash_key  = {symbol, symbol} ^ parent_code;
  assign pool_full = (nodes_used >= LW'(POOL_NODES));

  assign nd_sym    = node_rdata[NW-1 -: SW];
  assign nd_parent = node_rdata[NW-SW-1 -: CW];
  assign nd_child  = node_rdata[LW+CW-1 -: CW];
  assign nd_link   = node_rdata[LW-1:0];
  assign nd_match  = (nd_sym == sym_q) && (nd_parent == parent_q);

  // In the head-read cycle the head is still on the memory output.
  assign chain_head = (state == lzdht_pkg::ST_HEAD) ? head_rdata : head_q;

  assign head_raddr = BAW'(mod_rem);
  assign node_wdata = {sym_q, parent_q, code_q, chain_head};

  lzdht_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .key     (hash_key),
    .divisor (modulus),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  lzdht_ram #(
    .WIDTH (LW),
    .DEPTH (BUCKETS)
  ) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  lzdht_ram #(
    .WIDTH (NW),
    .DEPTH (POOL_NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (node_we),
    .waddr (NAW'(nodes_used)),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzdht_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mod_start  = 1'b0;
    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = nodes_used + LW'(1);
    node_we    = 1'b0;
    node_raddr = NAW'(head_rdata - LW'(1));
    set_result = 1'b0;
    set_status = lzdht_pkg::STATUS_NOT_FOUND;
    set_child  = '0;
    out_load   = 1'b0;
    unique case (state)
      lzdht_pkg::ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_addr;
        head_wdata = '0;
        if (clr_addr == BAW'(BUCKETS - 1)) begin
          state_next = lzdht_pkg::ST_IDLE;
        end
      end
      lzdht_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (func == lzdht_pkg::FUNC_INSERT && pool_full) begin
            set_result = 1'b1;
            set_status = lzdht_pkg::STATUS_FULL;
            state_next = lzdht_pkg::ST_DONE;
          end else begin
            mod_start  = 1'b1;
            state_next = lzdht_pkg::ST_HASH;
          end
        end
      end
      lzdht_pkg::ST_HASH: begin
        if (mod_done) begin
          state_next = lzdht_pkg::ST_HEAD;
        end
      end
      lzdht_pkg::ST_HEAD, lzdht_pkg::ST_WALK: begin
        if (state == lzdht_pkg::ST_WALK && nd_match) begin
          set_result = 1'b1;
          state_next = lzdht_pkg::ST_DONE;
          if (func_q == lzdht_pkg::FUNC_LOOKUP) begin
            set_status = lzdht_pkg::STATUS_FOUND;
            set_child  = nd_child;
          end else begin
            set_status = lzdht_pkg::STATUS_PRESENT;
          end
        end else if ((state == lzdht_pkg::ST_HEAD && head_rdata == '0) ||
                     (state == lzdht_pkg::ST_WALK && nd_link == '0)) begin
          // End of chain: miss; an insert links a new node at the head.
          set_result = 1'b1;
          state_next = lzdht_pkg::ST_DONE;
          if (func_q == lzdht_pkg::FUNC_LOOKUP) begin
            set_status = lzdht_pkg::STATUS_NOT_FOUND;
          end else begin
            set_status = lzdht_pkg::STATUS_INSERTED;
            node_we    = 1'b1;
            head_we    = 1'b1;
          end
        end else begin
          if (state == lzdht_pkg::ST_WALK) begin
            node_raddr = NAW'(nd_link - LW'(1));
          end
          state_next = lzdht_pkg::ST_WALK;
        end
      end
      lzdht_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = lzdht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lzdht_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= lzdht_pkg::BUCKET_COUNT_RESET;
      clr_addr     <= '0;
      nodes_used   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bucket_count <= cfg_wr_data;
      end
      if (state == lzdht_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + BAW'(1);
      end
      if (node_we) begin
        nodes_used <= nodes_used + LW'(1);
      end
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == lzdht_pkg::ST_IDLE && in_valid) begin
      func_q   <= func;
      sym_q    <= symbol;
      parent_q <= parent_code;
      code_q   <= new_code;
    end
    if (mod_done) begin
      bucket_q <= BAW'(mod_rem);
    end
    if (state == lzdht_pkg::ST_HEAD) begin
      head_q <= head_rdata;
    end
    if (set_result) begin
      res_status <= set_status;
      res_child  <= set_child;
    end
    if (out_load) begin
      status     <= res_status;
      child_code <= res_child;
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= LW'(POOL_NODES))
    else $error("node count exceeds the pool");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    node_we |-> !pool_full)
    else $error("node written into a full pool");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    node_we |=> nodes_used == $past(nodes_used) + LW'(1))
    else $error("node count did not advance on insert");

  a_child_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lzdht_pkg::STATUS_FOUND |-> child_code == '0)
    else $error("child code set on a result that is not a hit");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == lzdht_pkg::ST_CLEAR |-> !mod_start && !node_we)
    else $error("request work during the clearing pass");

endmodule
`default_nettype wire

@@ sim/lz78_dictionary_hash_table_top_tb.sv @@
`timescale 1ns / 100ps

module lz78_dictionary_hash_table_top_tb;
  import lzdht_pkg::*;

  // One answer of the dictionary: status plus the child code (zero unless found).
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   child;
  } dict_answer_t;

  // Key of a dictionary entry, kept so that later requests can hit stored entries.
  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic [CODE_W-1:0]   parent;
  } dict_key_t;

  // Shadow dictionary plus the queue of answers still owed by the block.
  class dict_scoreboard;
    logic [COUNT_W-1:0]  bucket_count;
    logic [COUNT_W-1:0]  heads       [BUCKETS_DEFAULT];
    logic [SYMBOL_W-1:0] node_sym    [POOL_NODES_DEFAULT];
    logic [CODE_W-1:0]   node_parent [POOL_NODES_DEFAULT];
    logic [CODE_W-1:0]   node_child  [POOL_NODES_DEFAULT];
    logic [COUNT_W-1:0]  node_link   [POOL_NODES_DEFAULT];
    int unsigned         nodes_used;
    dict_answer_t        awaited[$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         status_seen [5];

    function new();
      bucket_count = BUCKET_COUNT_RESET;
      foreach (heads[i]) heads[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      nodes_used = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    // Zero acts as one bucket, anything above the table size as the table size.
    function int unsigned modulus();
      if (bucket_count == 0) return 1;
      if (bucket_count > BUCKETS_DEFAULT) return BUCKETS_DEFAULT;
      return bucket_count;
    endfunction

    // symbol * 257 is the byte repeated in both halves of the 16-bit key.
    function int unsigned bucket_of(logic [SYMBOL_W-1:0] sym, logic [CODE_W-1:0] parent);
      logic [KEY_W-1:0] key;
      key = {sym, sym} ^ parent;
      return key % modulus();
    endfunction

    // Walk the chain; return node number plus one, or zero on a miss.
    function logic [COUNT_W-1:0] find_node(logic [SYMBOL_W-1:0] sym,
                                           logic [CODE_W-1:0] parent);
      logic [COUNT_W-1:0] link;
      int unsigned        steps;
      link  = heads[bucket_of(sym, parent)];
      steps = 0;
      while (link != 0 && steps < nodes_used) begin
        if (node_sym[link-1] == sym && node_parent[link-1] == parent) return link;
        link = node_link[link-1];
        steps++;
      end
      return '0;
    endfunction

    // Apply one accepted request to the shadow table and queue its answer.
    function dict_answer_t note_request(logic f, logic [SYMBOL_W-1:0] sym,
                                        logic [CODE_W-1:0] parent, logic [CODE_W-1:0] code);
      dict_answer_t       ans;
      logic [COUNT_W-1:0] hit;
      int unsigned        b;
      ans.child = '0;
      if (f == FUNC_LOOKUP) begin
        hit = find_node(sym, parent);
        if (hit != 0) begin
          ans.status = STATUS_FOUND;
          ans.child  = node_child[hit-1];
        end else begin
          ans.status = STATUS_NOT_FOUND;
        end
      end else if (nodes_used >= POOL_NODES_DEFAULT) begin
        ans.status = STATUS_FULL;
      end else if (find_node(sym, parent) != 0) begin
        ans.status = STATUS_PRESENT;
      end else begin
        b = bucket_of(sym, parent);
        node_sym[nodes_used]    = sym;
        node_parent[nodes_used] = parent;
        node_child[nodes_used]  = code;
        node_link[nodes_used]   = heads[b];
        heads[b]   = COUNT_W'(nodes_used + 1);
        nodes_used = nodes_used + 1;
        ans.status = STATUS_INSERTED;
      end
      awaited.push_back(ans);
      return ans;
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [CODE_W-1:0] ch);
      dict_answer_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: result with nothing awaited: status %0d child %h", $time, st, ch);
        return;
      end
      want = awaited.pop_front();
      if (!$isunknown(st) && st <= STATUS_FULL) status_seen[st]++;
      if (st !== want.status || ch !== want.child) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: expected status %0d child %h, got status %0d child %h",
                   $time, want.status, want.child, st, ch);
      end
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0]  cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                func        = FUNC_LOOKUP;
  logic [SYMBOL_W-1:0] symbol      = '0;
  logic [CODE_W-1:0]   parent_code = '0;
  logic [CODE_W-1:0]   new_code    = '0;
  logic                out_stall   = 1'b0;
  wire                 in_stall;
  wire                 out_valid;
  wire [STATUS_W-1:0]  status;
  wire [CODE_W-1:0]    child_code;

  // Traffic knobs, set by the main sequence between phases.
  int unsigned send_idle_pct     = 0;
  int unsigned recv_idle_pct     = 0;
  int unsigned recv_hold_cycles  = 0;
  int unsigned requests_sent     = 0;
  int unsigned settings_written  = 0;

  // LZ78 parse state: current prefix code, next free code, pending insert.
  logic [CODE_W-1:0]   lz_cursor    = '0;
  logic [CODE_W-1:0]   lz_next_code = 16'd1;
  logic [SYMBOL_W-1:0] lz_sym       = '0;
  bit                  lz_due       = 1'b0;
  dict_key_t           known_keys[$];

  dict_scoreboard board;

  always #1 clk = ~clk;

  lz78_dictionary_hash_table_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .symbol      (symbol),
    .parent_code (parent_code),
    .new_code    (new_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .child_code  (child_code)
  );

  // Receiver: honor a long hold-off first, counted down here, else stall at random.
  always @(negedge clk) begin
    if (recv_hold_cycles != 0) begin
      out_stall        <= 1'b1;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor: every accepted result goes against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_result(status, child_code);
  end

  // Offer one request, idling first at random; return the predicted answer on accept.
  task automatic send_request(input logic f, input logic [SYMBOL_W-1:0] s,
                              input logic [CODE_W-1:0] p, input logic [CODE_W-1:0] c,
                              output dict_answer_t ans);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    symbol      <= s;
    parent_code <= p;
    new_code    <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    ans = board.note_request(f, s, p, c);
    requests_sent++;
  endtask

  // Drop valid and hold until every owed answer has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the bucket count; only called with no requests in flight.
  task automatic set_bucket_count(input logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.bucket_count = v;
    settings_written++;
  endtask

  function automatic void remember(logic [SYMBOL_W-1:0] s, logic [CODE_W-1:0] p);
    dict_key_t k;
    k.sym    = s;
    k.parent = p;
    known_keys.push_back(k);
    if (known_keys.size() > 1024) void'(known_keys.pop_front());
  endfunction

  // Mostly an LZ78 parse over a small alphabet so the trie grows deep chains,
  // else hits on stored keys or fully random inserts and lookups.
  task automatic random_request();
    dict_answer_t        ans;
    int unsigned         pick;
    int unsigned         k;
    logic [SYMBOL_W-1:0] s;
    logic [CODE_W-1:0]   p;
    pick = $urandom_range(99);
    if (pick < 55) begin
      if (lz_due) begin
        send_request(FUNC_INSERT, lz_sym, lz_cursor, lz_next_code, ans);
        remember(lz_sym, lz_cursor);
        lz_next_code = lz_next_code + 1;
        lz_cursor    = '0;
        lz_due       = 1'b0;
      end else begin
        lz_sym = ($urandom_range(9) == 0) ? SYMBOL_W'($urandom) : SYMBOL_W'($urandom_range(3));
        send_request(FUNC_LOOKUP, lz_sym, lz_cursor, CODE_W'($urandom), ans);
        if (ans.status == STATUS_FOUND) lz_cursor = ans.child;
        else lz_due = 1'b1;
      end
    end else if (pick < 75 && known_keys.size() != 0) begin
      k = $urandom_range(known_keys.size() - 1);
      send_request(1'($urandom_range(1)), known_keys[k].sym, known_keys[k].parent,
                   CODE_W'($urandom), ans);
    end else begin
      s = SYMBOL_W'($urandom);
      p = CODE_W'($urandom);
      send_request((pick < 90) ? FUNC_INSERT : FUNC_LOOKUP, s, p, CODE_W'($urandom), ans);
      if (pick < 90) remember(s, p);
    end
  endtask

  // The run is cut off here if the block hangs.
  initial begin
    #20_000_000;
    $display("lz78_dictionary_hash_table_top test failed");
    $finish;
  end

  initial begin
    dict_answer_t ans;
    int unsigned  bc_plan [12];

    board = new();
    bc_plan = '{1, 0, 2, 7, 4097, 8191, 255, $urandom_range(3, 4094), 31, 4095, 1000, 4096};

    // Release reset after holding it; the block then sweeps its bucket heads with
    // in_stall high, and the first request simply waits for that.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one bucket (count zero), so every key shares a chain.
    send_idle_pct = 37;
    recv_idle_pct = 62;
    set_bucket_count(13'd0);
    send_request(FUNC_LOOKUP, 8'h00, 16'h0000, 16'h0000, ans);  // empty table
    send_request(FUNC_INSERT, 8'h00, 16'h0000, 16'hFFFF, ans);
    send_request(FUNC_INSERT, 8'hFF, 16'hFFFF, 16'h0000, ans);
    send_request(FUNC_INSERT, 8'hAA, 16'h5555, 16'h1234, ans);
    send_request(FUNC_LOOKUP, 8'h00, 16'h0000, 16'h0000, ans);  // tail of chain
    send_request(FUNC_LOOKUP, 8'hFF, 16'hFFFF, 16'hFFFF, ans);
    send_request(FUNC_LOOKUP, 8'hAA, 16'h5555, 16'h0000, ans);  // head of chain
    send_request(FUNC_INSERT, 8'h00, 16'h0000, 16'h7777, ans);  // already present
    send_request(FUNC_LOOKUP, 8'h55, 16'hAAAA, 16'h0000, ans);  // miss after full walk
    send_request(FUNC_INSERT, 8'h55, 16'hAAAA, 16'hFFFF, ans);  // duplicate child code
    send_request(FUNC_LOOKUP, 8'hFF, 16'h0000, 16'h0000, ans);  // symbol matches only
    send_request(FUNC_LOOKUP, 8'h00, 16'hFFFF, 16'h0000, ans);  // parent matches only
    remember(8'h00, 16'h0000);
    remember(8'hFF, 16'hFFFF);
    remember(8'hAA, 16'h5555);
    remember(8'h55, 16'hAAAA);

    // Change the modulus with entries in place: some old keys drop out of reach.
    drain();
    set_bucket_count(13'h1FFF);
    send_request(FUNC_LOOKUP, 8'h00, 16'h0000, 16'h0000, ans);
    send_request(FUNC_LOOKUP, 8'hFF, 16'hFFFF, 16'h0000, ans);
    send_request(FUNC_LOOKUP, 8'hAA, 16'h5555, 16'h0000, ans);
    send_request(FUNC_INSERT, 8'hAA, 16'h5555, 16'h0001, ans);  // re-added under new hash
    send_request(FUNC_LOOKUP, 8'hAA, 16'h5555, 16'h0000, ans);
    send_request(FUNC_INSERT, 8'h55, 16'hAAAA, 16'h8000, ans);

    // Random phases, each under its own bucket count. Small counts come first
    // while the pool is still small, so chain walks stay affordable.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      set_bucket_count(COUNT_W'(bc_plan[ph]));
      case (ph / 4)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (155) random_request();

      if (ph == 5) begin
        // Back-pressure: receiver holds off for a long stretch while the sender
        // keeps offering, so the output slot fills and the input stalls.
        drain();
        @(posedge clk);
        recv_hold_cycles = 300;
        send_idle_pct    = 0;
        repeat (12) random_request();
        // Then pause the sender until everything owed has come back.
        repeat (8) begin
          random_request();
          drain();
        end
        send_idle_pct = 62;
      end
    end

    // Repeat the newest stored key, then a fresh key, then mixed traffic.
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(FUNC_INSERT, known_keys[known_keys.size()-1].sym,
                 known_keys[known_keys.size()-1].parent, 16'h4321, ans);
    send_request(FUNC_INSERT, 8'h5A, 16'hA5A5, 16'h0F0F, ans);
    repeat (20) random_request();

    // One bucket again on a well-filled table, so lookups walk long chains.
    drain();
    set_bucket_count(13'd1);
    repeat (12) random_request();

    drain();
    repeat (200) @(posedge clk);
    if (board.awaited.size() != 0) begin
      $display("ERROR: %0d answers never arrived", board.awaited.size());
      board.errors += board.awaited.size();
    end

    $display("Covered %0d requests over %0d bucket-count settings; pool reached %0d nodes.",
             requests_sent, settings_written, board.nodes_used);
    $display("Answers: %0d found, %0d missed, %0d inserted, %0d present, %0d full; %0d errors.",
             board.status_seen[STATUS_FOUND], board.status_seen[STATUS_NOT_FOUND],
             board.status_seen[STATUS_INSERTED], board.status_seen[STATUS_PRESENT],
             board.status_seen[STATUS_FULL], board.errors);
    if (board.errors == 0) begin
      $display("lz78_dictionary_hash_table_top test passed");
    end else begin
      $display("lz78_dictionary_hash_table_top test failed");
    end
    $finish;
  end

endmodule
